>>> rtl/voxel_intensity_adjust_assert.svh
// Assertion macros used by the voxel intensity adjust back end.
`ifndef VOXEL_INTENSITY_ADJUST_ASSERT_SVH
`define VOXEL_INTENSITY_ADJUST_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define VIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define VIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/via_pkg.sv
// Types and constants shared by the voxel intensity adjust modules.
`timescale 1ns / 1ps
`default_nettype none
package via_pkg;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_UPPER     = 3'd1;
  localparam logic [2:0] REG_LOWER     = 3'd2;
  localparam logic [2:0] REG_AB_RATIO  = 3'd3;
  localparam logic [2:0] REG_FRACTIONS = 3'd4;
  localparam logic [2:0] REG_REF_DOSE  = 3'd5;
  localparam logic [2:0] REG_SCALE     = 3'd6;
  localparam logic [2:0] REG_BOUNDS    = 3'd7;

  localparam int MODE_CLAMP_HI = 0;
  localparam int MODE_CLAMP_LO = 1;
  localparam int MODE_DOSE     = 2;
  localparam int MODE_SCALE    = 3;
  localparam int MODE_STRETCH  = 4;

  localparam logic OP_APPLY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic op;
    logic first;
    logic sat;
  } via_ctl_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } via_mreq_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic busy;
  } via_mrsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOSE,
    S_DOSE_DIV1,
    S_DOSE_MUL,
    S_DOSE_DIV2,
    S_SCALE,
    S_SCALE_MUL,
    S_POST,
    S_STR_DIV,
    S_STR_MUL,
    S_EMIT
  } via_state_t;

endpackage
`default_nettype wire

>>> rtl/via_muldiv.sv
// Shared iterative unit: shift-and-add fixed-point multiply, restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module via_muldiv import via_pkg::*; #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire via_mreq_t            req,
  input  wire logic signed [VW-1:0] op_a,
  input  wire logic signed [VW-1:0] op_b,
  output via_mrsp_t                 rsp,
  output logic signed [VW-1:0]      res
);

  localparam int NW = VW + FB;
  localparam int MW = (2 * VW > NW) ? 2 * VW : NW;
  localparam int CW = $clog2(NW + 1);

  logic            busy_r, fin_r, done_r, div_r, neg_r, sat_r;
  logic [CW-1:0]   cnt_r;
  logic [VW-1:0]   mcand_r;
  logic [2*VW-1:0] acc_r;
  logic [NW-1:0]   num_r;
  logic [VW:0]     rem_r;
  logic signed [VW-1:0] res_r;

  logic [VW-1:0] mag_a, mag_b;
  logic [VW:0]   rem_sh, hsum;
  logic          ge;
  logic [MW-1:0] mag, lim, mclip;
  logic          over;
  logic [VW-1:0] mv;

  assign mag_a = op_a[VW-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b = op_b[VW-1] ? (~op_b + 1'b1) : op_b;

  assign rem_sh = {rem_r[VW-1:0], num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, mcand_r};
  assign hsum   = acc_r[0] ? ({1'b0, acc_r[2*VW-1:VW]} + {1'b0, mcand_r})
                           : {1'b0, acc_r[2*VW-1:VW]};

  // Magnitude limit: a negative result may reach one step further.
  assign mag   = div_r ? MW'(num_r) : MW'(acc_r >> FB);
  assign lim   = neg_r ? (MW'(1) << (VW - 1)) : ((MW'(1) << (VW - 1)) - MW'(1));
  assign over  = mag > lim;
  assign mclip = over ? lim : mag;
  assign mv    = mclip[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        div_r   <= req.is_div;
        neg_r   <= op_a[VW-1] ^ op_b[VW-1];
        mcand_r <= mag_b;
        acc_r   <= {{VW{1'b0}}, mag_a};
        num_r   <= NW'(mag_a) << FB;
        rem_r   <= '0;
        cnt_r   <= req.is_div ? CW'(NW) : CW'(VW);
      end else if (busy_r) begin
        if (div_r) begin
          rem_r <= ge ? (rem_sh - {1'b0, mcand_r}) : rem_sh;
          num_r <= {num_r[NW-2:0], ge};
        end else begin
          acc_r <= {hsum, acc_r[VW-1:1]};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        sat_r  <= over;
        res_r  <= neg_r ? $signed(~mv + 1'b1) : $signed(mv);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.busy = busy_r | fin_r;
  assign res      = res_r;

endmodule
`default_nettype wire

>>> rtl/via_front.sv
// Front end: takes an input word, saturates it and applies the clamps that the mode enables.
`timescale 1ns / 1ps
`default_nettype none
module via_front import via_pkg::*; #(
  parameter int VW = 32
) (
  input  wire logic                in_operation,
  input  wire logic                in_first_of_frame,
  input  wire logic signed [31:0]  in_voxel_value,
  input  wire logic [4:0]          mode,
  input  wire logic signed [31:0]  upper_limit,
  input  wire logic signed [31:0]  lower_limit,
  output via_ctl_t                 ctl,
  output logic signed [VW-1:0]     value
);

  localparam int EW = (VW > 32) ? VW : 32;
  localparam logic signed [EW:0] VMAX = {{(EW-VW+2){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [EW:0] VMIN = ~VMAX;

  function automatic logic signed [EW:0] ext32(input logic [31:0] x);
    return {{(EW-31){x[31]}}, x};
  endfunction

  // Returns the saturation flag above the value clipped to VALUE_WIDTH.
  function automatic logic [VW:0] clampw(input logic signed [EW:0] x);
    logic signed [EW:0] y;
    logic f;
    f = 1'b0;
    y = x;
    if (x > VMAX) begin
      y = VMAX;
      f = 1'b1;
    end else if (x < VMIN) begin
      y = VMIN;
      f = 1'b1;
    end
    return {f, y[VW-1:0]};
  endfunction

  logic [VW:0] v_p, u_p, l_p;
  logic signed [VW-1:0] u_v, l_v;

  assign v_p = clampw(ext32(in_voxel_value));
  assign u_p = clampw(ext32(upper_limit));
  assign l_p = clampw(ext32(lower_limit));
  assign u_v = $signed(u_p[VW-1:0]);
  assign l_v = $signed(l_p[VW-1:0]);

  always_comb begin
    value     = $signed(v_p[VW-1:0]);
    ctl.op    = in_operation;
    ctl.first = in_first_of_frame;
    ctl.sat   = v_p[VW];
    if (mode[MODE_CLAMP_HI]) begin
      ctl.sat = ctl.sat | u_p[VW];
      if (value > u_v) begin
        value = u_v;
      end
    end
    if (mode[MODE_CLAMP_LO]) begin
      ctl.sat = ctl.sat | l_p[VW];
      if (value < l_v) begin
        value = l_v;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/via_queue.sv
// Small register queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module via_queue #(
  parameter int W     = 35,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty,
  output logic              full
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW:0]  wp_r, rp_r;

  assign empty   = wp_r == rp_r;
  assign full    = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign rd_data = mem_r[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r[AW-1:0]] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/via_back.sv
// Back end: sequencer for dose rescale, scale, min-max tracking and stretch.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_intensity_adjust_assert.svh"
module via_back import via_pkg::*; #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [4:0]           mode,
  input  wire logic [31:0]          ab_ratio,
  input  wire logic [31:0]          fractions,
  input  wire logic [31:0]          ref_dose,
  input  wire logic [31:0]          scale,
  input  wire logic [31:0]          bound_lo,
  input  wire logic [31:0]          bound_hi,
  input  wire logic                 q_empty,
  input  wire via_ctl_t             q_ctl,
  input  wire logic signed [VW-1:0] q_value,
  output logic                      q_pop,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic signed [31:0]        out_adjusted_value,
  output logic [1:0]                out_status
);

  localparam int EW = (VW > 32) ? VW : 32;
  localparam logic signed [EW:0] VMAX  = {{(EW-VW+2){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [EW:0] VMIN  = ~VMAX;
  localparam logic signed [EW:0] O_MAX = {{(EW-30){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW:0] O_MIN = ~O_MAX;

  function automatic logic signed [EW:0] ext32(input logic [31:0] x);
    return {{(EW-31){x[31]}}, x};
  endfunction

  function automatic logic signed [EW:0] extv(input logic [VW-1:0] x);
    return {{(EW-VW+1){x[VW-1]}}, x};
  endfunction

  function automatic logic [VW:0] clampw(input logic signed [EW:0] x);
    logic signed [EW:0] y;
    logic f;
    f = 1'b0;
    y = x;
    if (x > VMAX) begin
      y = VMAX;
      f = 1'b1;
    end else if (x < VMIN) begin
      y = VMIN;
      f = 1'b1;
    end
    return {f, y[VW-1:0]};
  endfunction

  // The sum of two values fits one bit above VALUE_WIDTH, so EW+1 bits are exact.
  function automatic logic [VW:0] addsub(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                         input logic sub);
    logic signed [EW:0] s;
    s = sub ? (extv(a) - extv(b)) : (extv(a) + extv(b));
    return clampw(s);
  endfunction

  via_state_t state_r, state_nxt;
  logic signed [VW-1:0] v_r, v_nxt, min_r, min_nxt, max_r, max_nxt;
  logic zf_r, zf_nxt, sf_r, sf_nxt, op_r, op_nxt, first_r, first_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] out_val_r, out_val_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic out_load;

  via_mreq_t u_req;
  via_mrsp_t u_rsp;
  logic signed [VW-1:0] u_a, u_b, u_res;

  via_muldiv #(.VW(VW), .FB(FB)) u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (u_req),
    .op_a (u_a),
    .op_b (u_b),
    .rsp  (u_rsp),
    .res  (u_res)
  );

  logic [VW:0] ab_p, n_p, d_p, sc_p, lo_p, hi_p, den_p, s_p, rng_p, dif_p, hl_p, sum_p;
  logic dose_zero, range_zero;
  logic signed [EW:0] ov;
  logic osat;
  logic signed [31:0] o32;

  assign ab_p  = clampw(ext32(ab_ratio));
  assign n_p   = clampw(ext32(fractions));
  assign d_p   = clampw(ext32(ref_dose));
  assign sc_p  = clampw(ext32(scale));
  assign lo_p  = clampw(ext32(bound_lo));
  assign hi_p  = clampw(ext32(bound_hi));
  assign den_p = addsub(ab_p[VW-1:0], d_p[VW-1:0], 1'b0);
  assign s_p   = addsub(ab_p[VW-1:0], u_res, 1'b0);
  assign rng_p = addsub(max_r, min_r, 1'b1);
  assign dif_p = addsub(v_r, min_r, 1'b1);
  assign hl_p  = addsub(hi_p[VW-1:0], lo_p[VW-1:0], 1'b1);
  assign sum_p = addsub(u_res, lo_p[VW-1:0], 1'b0);

  assign dose_zero  = (n_p[VW-1:0] == '0) || (den_p[VW-1:0] == '0);
  assign range_zero = rng_p[VW-1:0] == '0;

  assign ov   = extv(v_r);
  assign osat = (ov > O_MAX) || (ov < O_MIN);
  assign o32  = (ov > O_MAX) ? O_MAX[31:0] : ((ov < O_MIN) ? O_MIN[31:0] : ov[31:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = mode[MODE_DOSE] ? S_DOSE : S_SCALE;
        end
      end
      S_DOSE:      state_nxt = dose_zero ? S_SCALE : S_DOSE_DIV1;
      S_DOSE_DIV1: if (u_rsp.done) state_nxt = S_DOSE_MUL;
      S_DOSE_MUL:  if (u_rsp.done) state_nxt = S_DOSE_DIV2;
      S_DOSE_DIV2: if (u_rsp.done) state_nxt = S_SCALE;
      S_SCALE:     state_nxt = mode[MODE_SCALE] ? S_SCALE_MUL : S_POST;
      S_SCALE_MUL: if (u_rsp.done) state_nxt = S_POST;
      S_POST: begin
        if (op_r != OP_APPLY) begin
          state_nxt = S_IDLE;
        end else if (mode[MODE_STRETCH] && !range_zero) begin
          state_nxt = S_STR_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_STR_DIV:   if (u_rsp.done) state_nxt = S_STR_MUL;
      S_STR_MUL:   if (u_rsp.done) state_nxt = S_EMIT;
      S_EMIT:      if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    v_nxt          = v_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    zf_nxt         = zf_r;
    sf_nxt         = sf_r;
    op_nxt         = op_r;
    first_nxt      = first_r;
    q_pop          = 1'b0;
    u_req.start    = 1'b0;
    u_req.is_div   = 1'b0;
    u_a            = v_r;
    u_b            = v_r;
    out_load       = 1'b0;
    out_val_nxt    = out_val_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          v_nxt     = q_value;
          op_nxt    = q_ctl.op;
          first_nxt = q_ctl.first;
          sf_nxt    = q_ctl.sat;
          zf_nxt    = 1'b0;
        end
      end
      S_DOSE: begin
        sf_nxt = sf_r | ab_p[VW] | n_p[VW] | d_p[VW] | den_p[VW];
        if (dose_zero) begin
          zf_nxt = 1'b1;
          v_nxt  = '0;
        end else begin
          u_req.start  = 1'b1;
          u_req.is_div = 1'b1;
          u_b          = $signed(n_p[VW-1:0]);
        end
      end
      S_DOSE_DIV1: begin
        if (u_rsp.done) begin
          sf_nxt      = sf_r | u_rsp.sat | s_p[VW];
          u_req.start = 1'b1;
          u_b         = $signed(s_p[VW-1:0]);
        end
      end
      S_DOSE_MUL: begin
        if (u_rsp.done) begin
          sf_nxt       = sf_r | u_rsp.sat;
          u_req.start  = 1'b1;
          u_req.is_div = 1'b1;
          u_a          = u_res;
          u_b          = $signed(den_p[VW-1:0]);
        end
      end
      S_DOSE_DIV2, S_SCALE_MUL: begin
        if (u_rsp.done) begin
          sf_nxt = sf_r | u_rsp.sat;
          v_nxt  = u_res;
        end
      end
      S_SCALE: begin
        if (mode[MODE_SCALE]) begin
          sf_nxt      = sf_r | sc_p[VW];
          u_req.start = 1'b1;
          u_b         = $signed(sc_p[VW-1:0]);
        end
      end
      S_POST: begin
        if (op_r != OP_APPLY) begin
          if (first_r) begin
            min_nxt = v_r;
            max_nxt = v_r;
          end else begin
            if (v_r > max_r) max_nxt = v_r;
            if (v_r < min_r) min_nxt = v_r;
          end
        end else if (mode[MODE_STRETCH]) begin
          if (range_zero) begin
            sf_nxt = sf_r | rng_p[VW];
            zf_nxt = 1'b1;
            v_nxt  = '0;
          end else begin
            sf_nxt       = sf_r | rng_p[VW] | dif_p[VW] | lo_p[VW] | hi_p[VW] | hl_p[VW];
            u_req.start  = 1'b1;
            u_req.is_div = 1'b1;
            u_a          = $signed(dif_p[VW-1:0]);
            u_b          = $signed(rng_p[VW-1:0]);
          end
        end
      end
      S_STR_DIV: begin
        if (u_rsp.done) begin
          sf_nxt      = sf_r | u_rsp.sat;
          u_req.start = 1'b1;
          u_a         = u_res;
          u_b         = $signed(hl_p[VW-1:0]);
        end
      end
      S_STR_MUL: begin
        if (u_rsp.done) begin
          sf_nxt = sf_r | u_rsp.sat | sum_p[VW];
          v_nxt  = $signed(sum_p[VW-1:0]);
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load       = 1'b1;
          out_val_nxt    = o32;
          out_status_nxt = zf_r ? ST_ZERO : ((sf_r | osat) ? ST_SAT : ST_OK);
        end
      end
      default: begin
        v_nxt = v_r;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    zf_r         <= zf_nxt;
    sf_r         <= sf_nxt;
    op_r         <= op_nxt;
    first_r      <= first_nxt;
    out_val_r    <= out_val_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_adjusted_value = out_val_r;
  assign out_status         = out_status_r;

  `VIA_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty)
  `VIA_ASSERT_IMP(a_load_free, out_load, !out_valid_r || out_ready)
  `VIA_ASSERT_IMP(a_unit_idle, u_req.start, !u_rsp.busy)
  `VIA_ASSERT_IMP(a_done_waited, u_rsp.done,
                  state_r == S_DOSE_DIV1 || state_r == S_DOSE_MUL ||
                  state_r == S_DOSE_DIV2 || state_r == S_SCALE_MUL ||
                  state_r == S_STR_DIV || state_r == S_STR_MUL)

endmodule
`default_nettype wire

>>> rtl/voxel_intensity_adjust.sv
// Top level of the voxel intensity adjust block: registers, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none
// Voxel intensity adjust: each word is saturated and clamped by the enabled
// limits in the front end in the cycle it is accepted and written to a
// four-word queue, so the input keeps flowing while the back end works, until
// the queue is full. The back end handles one word at a time with a single
// shared multiply/divide unit and takes each word through its steps in order:
// taking it from the queue, the dose and scale decisions, the post step and
// loading the output register. A stalled output holds the back end until the
// output register is free. Measure words update the running minimum and
// maximum and give no result; apply words give one result in an output
// register.
module voxel_intensity_adjust import via_pkg::*; #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_operation,
  input  wire logic         in_first_of_frame,
  input  wire logic [31:0]  in_voxel_value,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       out_adjusted_value,
  output logic [1:0]        out_status,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int QW = VW + $bits(via_ctl_t);

  logic [4:0]  mode_r;
  logic [31:0] upper_r, lower_r, ab_r, frac_r, dose_r, scale_r;
  logic [63:0] bounds_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      upper_r  <= 32'h7fff_ffff;
      lower_r  <= 32'h8000_0000;
      ab_r     <= 32'h000a_0000;
      frac_r   <= 32'h0001_0000;
      dose_r   <= 32'h0002_0000;
      scale_r  <= 32'h0001_0000;
      bounds_r <= 64'h0001_0000_0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:      mode_r   <= cfg_data[4:0];
        REG_UPPER:     upper_r  <= cfg_data[31:0];
        REG_LOWER:     lower_r  <= cfg_data[31:0];
        REG_AB_RATIO:  ab_r     <= cfg_data[31:0];
        REG_FRACTIONS: frac_r   <= cfg_data[31:0];
        REG_REF_DOSE:  dose_r   <= cfg_data[31:0];
        REG_SCALE:     scale_r  <= cfg_data[31:0];
        REG_BOUNDS:    bounds_r <= cfg_data;
        default:       mode_r   <= mode_r;
      endcase
    end
  end

  via_ctl_t f_ctl, q_ctl;
  logic signed [VW-1:0] f_value, q_value;
  logic [QW-1:0] q_rd;
  logic q_empty, q_full, q_pop, push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  via_front #(.VW(VW)) u_front (
    .in_operation     (in_operation),
    .in_first_of_frame(in_first_of_frame),
    .in_voxel_value   (in_voxel_value),
    .mode             (mode_r),
    .upper_limit      (upper_r),
    .lower_limit      (lower_r),
    .ctl              (f_ctl),
    .value            (f_value)
  );

  via_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data({f_ctl, f_value}),
    .pop    (q_pop),
    .rd_data(q_rd),
    .empty  (q_empty),
    .full   (q_full)
  );

  assign q_ctl   = q_rd[QW-1:VW];
  assign q_value = $signed(q_rd[VW-1:0]);

  via_back #(.VW(VW), .FB(FRACTION_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mode              (mode_r),
    .ab_ratio          (ab_r),
    .fractions         (frac_r),
    .ref_dose          (dose_r),
    .scale             (scale_r),
    .bound_lo          (bounds_r[31:0]),
    .bound_hi          (bounds_r[63:32]),
    .q_empty           (q_empty),
    .q_ctl             (q_ctl),
    .q_value           (q_value),
    .q_pop             (q_pop),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_adjusted_value(out_adjusted_value),
    .out_status        (out_status)
  );

endmodule
`default_nettype wire
